### rtl/exl_pkg.sv
// Shared types, constants and token codes for the expression lexer.
package exl_pkg;

    localparam int MAX_INPUT_LENGTH = 65536;
    localparam int OFFSET_W         = 17;
    localparam int VALUE_W          = 32;
    localparam int QUEUE_DEPTH      = 4;
    localparam int TOKENS_PER_CHAR  = 3;

    typedef enum logic [3:0] {
        KIND_NUMBER = 4'd0,
        KIND_PLUS   = 4'd1,
        KIND_MINUS  = 4'd2,
        KIND_STAR   = 4'd3,
        KIND_SLASH  = 4'd4,
        KIND_POWER  = 4'd5,
        KIND_LPAREN = 4'd6,
        KIND_RPAREN = 4'd7,
        KIND_EQUAL  = 4'd8,
        KIND_COMMA  = 4'd9,
        KIND_IDENT  = 4'd10,
        KIND_DEF    = 4'd11,
        KIND_END    = 4'd12,
        KIND_ERROR  = 4'd13
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_OCT  = 2'd1,
        ERR_HEX  = 2'd2,
        ERR_DEC  = 2'd3
    } t_err;

    typedef struct packed {
        t_kind                 kind;
        logic [VALUE_W-1:0]    value;
        logic [OFFSET_W-1:0]   start;
        logic [OFFSET_W-1:0]   len;
        t_err                  err;
        logic                  last;
    } t_token;

    // All tokens caused by one character, in order; only the first cnt are meaningful.
    typedef struct packed {
        logic [1:0]                    cnt;
        t_token [TOKENS_PER_CHAR-1:0]  tok;
    } t_bundle;

endpackage

### rtl/exl_if.sv
// Handshake interfaces for the character input and the token output.
interface exl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last_char;

    modport source (output valid, output ch, output last_char, input ready);
    modport sink   (input valid, input ch, input last_char, output ready);
endinterface

interface exl_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [31:0] token_value;
    logic [16:0] start_offset;
    logic [16:0] token_length;
    logic [1:0]  error_code;
    logic        last_result;

    modport source (output valid, output token_kind, output token_value,
                    output start_offset, output token_length, output error_code,
                    output last_result, input ready);
    modport sink   (input valid, input token_kind, input token_value,
                    input start_offset, input token_length, input error_code,
                    input last_result, output ready);
endinterface

### rtl/expression_lexer.sv
// Top level of the streaming expression lexer.
//
// i_chr takes one character per item with a last_char flag; o_tok gives
// tokens: kind, numeric value, start offset, length, error code and a flag on
// the final token caused by each character. Items move when valid and ready
// are both high.
// A character's tokens pass through the queue and then the output register.
// Characters are taken at one per cycle while the queue has room; a character
// that causes two or three tokens (separator after a word, final character)
// has them given out one token per cycle while the receiver is ready.
// The scanner writes each character's tokens into a four-entry queue, so
// input stops only when that queue is full; ready does not depend on the
// output side's ready in the same cycle.
// Reset (synchronous, active low) empties the queue and output register and
// returns the scanner to its idle state at offset zero. The final character
// of an expression also returns the scanner to that state.
// When the receiver stalls, the presented token holds until taken.
module expression_lexer
    import exl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    exl_char_if.sink    i_chr,
    exl_token_if.source o_tok
);

    logic    accept, push, pop, empty, full;
    t_bundle bundle, head;
    t_token  out_tok;
    logic    out_valid;

    assign i_chr.ready = !full;
    assign accept      = i_chr.valid && !full;

    exl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_ch     (i_chr.ch),
        .i_last   (i_chr.last_char),
        .o_push   (push),
        .o_bundle (bundle)
    );

    exl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (bundle),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    exl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_out_ready (o_tok.ready),
        .o_out_valid (out_valid),
        .o_out_tok   (out_tok)
    );

    assign o_tok.valid        = out_valid;
    assign o_tok.token_kind   = out_tok.kind;
    assign o_tok.token_value  = out_tok.value;
    assign o_tok.start_offset = out_tok.start;
    assign o_tok.token_length = out_tok.len;
    assign o_tok.error_code   = out_tok.err;
    assign o_tok.last_result  = out_tok.last;

endmodule

### rtl/exl_front.sv
// Scanner: classifies each character and builds the tokens it causes.
module exl_front
    import exl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_ch,
    input  logic        i_last,
    output logic        o_push,
    output t_bundle     o_bundle
);

    typedef enum logic [2:0] {
        M_IDLE, M_IDENT, M_ZERO, M_OCT, M_HEX, M_DEC, M_ERR
    } t_mode;

    localparam logic [2:0] KW_NONE = 3'd0;
    localparam logic [2:0] KW_D    = 3'd1;
    localparam logic [2:0] KW_DE   = 3'd2;
    localparam logic [2:0] KW_DEF  = 3'd3;
    localparam logic [2:0] KW_FAIL = 3'd7;
    localparam logic [OFFSET_W-1:0] MAX_OFF = OFFSET_W'(MAX_INPUT_LENGTH);

    t_mode               r_mode, n_mode;
    logic [VALUE_W-1:0]  r_acc, n_acc;
    logic [OFFSET_W-1:0] r_start, n_start;
    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic [2:0]          r_kw, n_kw;

    logic [OFFSET_W-1:0] p, next;
    logic                ws, sym, digit, octal, hex_letter_lo, hex_letter_hi, term;
    t_kind               sym_kind;
    logic [1:0]          k;
    t_token [TOKENS_PER_CHAR-1:0] toks;

    function automatic t_token make_tok(t_kind kind, logic [VALUE_W-1:0] val,
                                        logic [OFFSET_W-1:0] st,
                                        logic [OFFSET_W-1:0] len, t_err e);
        t_token t;
        t.kind  = kind;
        t.value = val;
        t.start = st;
        t.len   = len;
        t.err   = e;
        t.last  = 1'b0;
        return t;
    endfunction

    // Token for the identifier or number that ends just before offset stop.
    function automatic t_token flush_tok(t_mode m, logic [2:0] kw, logic [VALUE_W-1:0] acc,
                                         logic [OFFSET_W-1:0] st,
                                         logic [OFFSET_W-1:0] stop);
        t_token t;
        if (m == M_IDENT) begin
            t = make_tok((kw == KW_DEF) ? KIND_DEF : KIND_IDENT, '0, st, stop - st, ERR_NONE);
        end else begin
            t = make_tok(KIND_NUMBER, acc, st, stop - st, ERR_NONE);
        end
        return t;
    endfunction

    always_comb begin
        sym      = 1'b1;
        sym_kind = KIND_PLUS;
        case (i_ch)
            "+":     sym_kind = KIND_PLUS;
            "-":     sym_kind = KIND_MINUS;
            "*":     sym_kind = KIND_STAR;
            "/":     sym_kind = KIND_SLASH;
            "^":     sym_kind = KIND_POWER;
            "(":     sym_kind = KIND_LPAREN;
            ")":     sym_kind = KIND_RPAREN;
            "=":     sym_kind = KIND_EQUAL;
            ",":     sym_kind = KIND_COMMA;
            default: sym = 1'b0;
        endcase
    end

    assign ws            = (i_ch == " ") || (i_ch == 8'h09) || (i_ch == 8'h0a);
    assign term          = ws || sym;
    assign digit         = (i_ch >= "0") && (i_ch <= "9");
    assign octal         = (i_ch >= "0") && (i_ch <= "7");
    assign hex_letter_lo = (i_ch >= "a") && (i_ch <= "f");
    assign hex_letter_hi = (i_ch >= "A") && (i_ch <= "F");
    assign p             = r_offset;
    assign next          = (p < MAX_OFF) ? p + 1'b1 : MAX_OFF;

    always_comb begin
        n_mode   = r_mode;
        n_acc    = r_acc;
        n_start  = r_start;
        n_kw     = r_kw;
        n_offset = next;
        k        = 2'd0;
        toks     = '0;

        // A separator closes a pending identifier or number first.
        if (n_mode != M_IDLE && n_mode != M_ERR && term) begin
            toks[k] = flush_tok(n_mode, n_kw, n_acc, n_start, p);
            k       = k + 2'd1;
            n_mode  = M_IDLE;
        end

        case (n_mode)
            M_IDLE: begin
                if (ws) begin
                    n_mode = M_IDLE;
                end else if (sym) begin
                    toks[k] = make_tok(sym_kind, '0, p, OFFSET_W'(1), ERR_NONE);
                    k       = k + 2'd1;
                end else if (digit) begin
                    n_start = p;
                    n_acc   = VALUE_W'(i_ch[3:0]);
                    n_mode  = (i_ch == "0") ? M_ZERO : M_DEC;
                end else begin
                    n_start = p;
                    n_mode  = M_IDENT;
                    n_kw    = (i_ch == "d") ? KW_D : KW_FAIL;
                end
            end
            M_IDENT: begin
                if (n_kw == KW_D && i_ch == "e") begin
                    n_kw = KW_DE;
                end else if (n_kw == KW_DE && i_ch == "f") begin
                    n_kw = KW_DEF;
                end else begin
                    n_kw = KW_FAIL;
                end
            end
            M_ZERO, M_OCT: begin
                if (n_mode == M_ZERO && i_ch == "x") begin
                    n_mode = M_HEX;
                end else if (octal) begin
                    n_acc  = {n_acc[VALUE_W-4:0], i_ch[2:0]};
                    n_mode = M_OCT;
                end else begin
                    toks[k] = make_tok(KIND_ERROR, '0, n_start, p + 1'b1 - n_start, ERR_OCT);
                    k       = k + 2'd1;
                    n_mode  = M_ERR;
                end
            end
            M_HEX: begin
                if (digit) begin
                    n_acc = {n_acc[VALUE_W-5:0], i_ch[3:0]};
                end else if (hex_letter_lo || hex_letter_hi) begin
                    n_acc = {n_acc[VALUE_W-5:0], i_ch[3:0] + 4'd9};
                end else begin
                    toks[k] = make_tok(KIND_ERROR, '0, n_start, p + 1'b1 - n_start, ERR_HEX);
                    k       = k + 2'd1;
                    n_mode  = M_ERR;
                end
            end
            M_DEC: begin
                if (digit) begin
                    // Times ten as eight plus two.
                    n_acc = {n_acc[VALUE_W-4:0], 3'b000} + {n_acc[VALUE_W-2:0], 1'b0}
                            + VALUE_W'(i_ch[3:0]);
                end else begin
                    toks[k] = make_tok(KIND_ERROR, '0, n_start, p + 1'b1 - n_start, ERR_DEC);
                    k       = k + 2'd1;
                    n_mode  = M_ERR;
                end
            end
            default: begin
                n_mode = r_mode;
            end
        endcase

        if (i_last) begin
            if (n_mode != M_IDLE && n_mode != M_ERR) begin
                toks[k] = flush_tok(n_mode, n_kw, n_acc, n_start, next);
                k       = k + 2'd1;
            end
            toks[k]  = make_tok(KIND_END, '0, next, '0, ERR_NONE);
            k        = k + 2'd1;
            n_mode   = M_IDLE;
            n_acc    = '0;
            n_start  = '0;
            n_offset = '0;
            n_kw     = KW_NONE;
        end

        if (k != 2'd0) begin
            toks[2'(k - 2'd1)].last = 1'b1;
        end
    end

    assign o_push       = i_accept && (k != 2'd0);
    assign o_bundle.cnt = k;
    assign o_bundle.tok = toks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_acc    <= '0;
            r_start  <= '0;
            r_offset <= '0;
            r_kw     <= KW_NONE;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_acc    <= n_acc;
            r_start  <= n_start;
            r_offset <= n_offset;
            r_kw     <= n_kw;
        end
    end

endmodule

### rtl/exl_queue.sv
// Short queue of per-character token bundles between scanner and output stage.
module exl_queue
    import exl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    input  logic    i_pop,
    output t_bundle o_head,
    output logic    o_empty,
    output logic    o_full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_bundle            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/exl_back.sv
// Output stage: unpacks queued bundles and presents one registered token at a time.
module exl_back
    import exl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_bundle i_head,
    input  logic    i_empty,
    output logic    o_pop,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_token  o_out_tok
);

    logic       r_valid;
    t_token     r_tok;
    logic [1:0] r_sub;
    logic       load, take, sub_last;

    assign load     = !r_valid || i_out_ready;
    assign take     = load && !i_empty;
    assign sub_last = (r_sub == 2'(i_head.cnt - 2'd1));
    assign o_pop    = take && sub_last;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_tok <= i_head.tok[r_sub];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= '0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (take) begin
                r_sub <= sub_last ? 2'd0 : r_sub + 2'd1;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_tok   = r_tok;

endmodule
